// ===== rtl/core/gges_pkg.sv =====
// shared types, constants and the log table for the gillespie step core
package gges_pkg;

   localparam int COUNT_BITS      = 16;
   localparam int TIME_FRAC_BITS  = 16;
   localparam int LOG_TABLE_DEPTH = 256;
   localparam int TIME_BITS       = 48;
   localparam int RATE_BITS       = 32;
   localparam int U_BITS          = 32;
   localparam int PROP_BITS       = RATE_BITS + COUNT_BITS;
   localparam int K_BITS          = PROP_BITS + 2;
   localparam int NL_BITS         = U_BITS + 6;
   localparam int DIVIDEND_BITS   = NL_BITS + TIME_FRAC_BITS;
   localparam int TBL_IDX_BITS    = $clog2(LOG_TABLE_DEPTH + 1);
   localparam int POS_BITS        = U_BITS + TBL_IDX_BITS;
   localparam int E_BITS          = $clog2(U_BITS);
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 48;
   localparam int REACTION_BITS   = 3;

   localparam logic [U_BITS-1:0]    LN2_Q32   = 32'd2977044472;
   localparam logic [TIME_BITS-1:0] TIME_MAX  = {TIME_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MRNA_BIRTH    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MRNA_DECAY    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROTEIN_BIRTH = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROTEIN_DECAY = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HORIZON       = 3'd4;

   typedef enum logic [REACTION_BITS-1:0] {
      RX_MRNA_BIRTH    = 3'd0,
      RX_MRNA_DECAY    = 3'd1,
      RX_PROTEIN_BIRTH = 3'd2,
      RX_PROTEIN_DECAY = 3'd3,
      RX_NONE          = 3'd4
   } reaction_type;

   typedef enum logic [2:0] {
      S_IDLE, S_PROP, S_LOG, S_DIV, S_UPD, S_EMIT
   } ctl_state_type;

   typedef enum logic [2:0] {
      N_IDLE, N_NORM, N_IDX, N_RDLO, N_RDHI, N_MUL, N_SUB
   } nl_state_type;

   typedef logic [U_BITS-1:0] ln_table_type [LOG_TABLE_DEPTH+1];

   // ln(1 + i/D) by the atanh series, truncating each step
   function automatic ln_table_type build_ln_table();
      ln_table_type t;
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] term;
      logic [63:0] sum;
      int i;
      int k;
      for (i = 0; i <= LOG_TABLE_DEPTH; i++) begin
         z = (64'(i) << 32) / 64'(2 * LOG_TABLE_DEPTH + i);
         z2 = (z * z) >> 32;
         term = z;
         sum = 64'd0;
         for (k = 0; k < 32; k++) begin
            if (term != 64'd0) begin
               sum = sum + term / 64'(2 * k + 1);
               term = (term * z2) >> 32;
            end
         end
         t[i] = U_BITS'(sum << 1);
      end
      return t;
   endfunction

   localparam ln_table_type LN_TABLE = build_ln_table();

endpackage

// ===== rtl/core/gges_if.sv =====
// request and response channel interfaces
interface gges_req_if;
   logic                        valid;
   logic                        ready;
   logic [gges_pkg::U_BITS-1:0] u_time;
   logic [gges_pkg::U_BITS-1:0] u_pick;
   logic                        restart;
   modport source (output valid, u_time, u_pick, restart, input ready);
   modport sink (input valid, u_time, u_pick, restart, output ready);
endinterface

interface gges_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [gges_pkg::TIME_BITS-1:0]     elapsed_time;
   logic [gges_pkg::COUNT_BITS-1:0]    mrna_out;
   logic [gges_pkg::COUNT_BITS-1:0]    protein_out;
   logic [gges_pkg::REACTION_BITS-1:0] reaction;
   logic                               horizon_reached;
   modport source (output valid, elapsed_time, mrna_out, protein_out, reaction,
                   horizon_reached, input ready);
   modport sink (input valid, elapsed_time, mrna_out, protein_out, reaction,
                 horizon_reached, output ready);
endinterface

// ===== rtl/core/gges_neglog.sv =====
// -ln(u / 2^32) by bit-serial normalise, table lookup and interpolation
module gges_neglog (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gges_pkg::U_BITS-1:0]   u_value,
   output logic                          nl_valid,
   output logic [gges_pkg::NL_BITS-1:0]  nl_value
);
   import gges_pkg::*;

   nl_state_type state_ff, state_in;
   logic [U_BITS-1:0]       norm_ff;
   logic [E_BITS-1:0]       e_ff;
   logic [TBL_IDX_BITS-1:0] j_ff;
   logic [U_BITS-1:0]       w_ff;
   logic [U_BITS-1:0]       lo_ff;
   logic [U_BITS-1:0]       hi_ff;
   logic [2*U_BITS-1:0]     prod_ff;
   logic [NL_BITS-1:0]      whole_ff;
   logic [NL_BITS-1:0]      nl_ff;
   logic                    valid_ff;

   logic [U_BITS-1:0]   frac;
   logic [POS_BITS-1:0] pos;
   logic [U_BITS:0]     diff;
   logic [U_BITS:0]     lnm;
   logic [5:0]          whole_mult;

   assign frac = {norm_ff[U_BITS-2:0], 1'b0};
   assign pos = POS_BITS'(frac) * POS_BITS'(LOG_TABLE_DEPTH);
   assign diff = (hi_ff >= lo_ff) ? ({1'b0, hi_ff} - {1'b0, lo_ff}) : '0;
   assign lnm = {1'b0, lo_ff} + {1'b0, prod_ff[2*U_BITS-1:U_BITS]};
   assign whole_mult = 6'd32 - {1'b0, e_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (start) begin
            valid_ff <= 1'b0;
         end else if (state_ff == N_SUB) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         norm_ff <= u_value;
         e_ff <= E_BITS'(U_BITS - 1);
      end else begin
         unique case (state_ff)
            N_NORM: begin
               if (!norm_ff[U_BITS-1]) begin
                  norm_ff <= {norm_ff[U_BITS-2:0], 1'b0};
                  e_ff <= e_ff - 1'b1;
               end
            end
            N_IDX: begin
               if (pos[POS_BITS-1:U_BITS] >= TBL_IDX_BITS'(LOG_TABLE_DEPTH)) begin
                  j_ff <= TBL_IDX_BITS'(LOG_TABLE_DEPTH - 1);
                  w_ff <= '1;
               end else begin
                  j_ff <= pos[POS_BITS-1:U_BITS];
                  w_ff <= pos[U_BITS-1:0];
               end
            end
            N_RDLO: lo_ff <= LN_TABLE[j_ff];
            N_RDHI: hi_ff <= LN_TABLE[TBL_IDX_BITS'(j_ff + 1'b1)];
            N_MUL: begin
               prod_ff <= diff[U_BITS-1:0] * w_ff;
               whole_ff <= NL_BITS'(whole_mult) * NL_BITS'(LN2_Q32);
            end
            N_SUB: begin
               nl_ff <= (whole_ff > NL_BITS'(lnm)) ? (whole_ff - NL_BITS'(lnm)) : '0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      if (start) begin
         state_in = N_NORM;
      end else begin
         unique case (state_ff)
            N_IDLE: state_in = N_IDLE;
            N_NORM: if (norm_ff[U_BITS-1]) state_in = N_IDX;
            N_IDX:  state_in = N_RDLO;
            N_RDLO: state_in = N_RDHI;
            N_RDHI: state_in = N_MUL;
            N_MUL:  state_in = N_SUB;
            N_SUB:  state_in = N_IDLE;
            default: state_in = N_IDLE;
         endcase
      end
   end

   assign nl_valid = valid_ff;
   assign nl_value = nl_ff;

endmodule

// ===== rtl/core/gges_div.sv =====
// restoring divider, one quotient bit per cycle
module gges_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [gges_pkg::DIVIDEND_BITS-1:0]  dividend,
   input  logic [gges_pkg::K_BITS-1:0]         divisor,
   output logic                                done,
   output logic [gges_pkg::DIVIDEND_BITS-1:0]  quotient
);
   import gges_pkg::*;

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [DIVIDEND_BITS-1:0] quo_ff;
   logic [K_BITS-1:0]        rem_ff;
   logic [K_BITS-1:0]        den_ff;
   logic [CNT_BITS-1:0]      cnt_ff;
   logic                     busy_ff;
   logic                     done_ff;

   logic [K_BITS:0] trial;
   logic            fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign fits = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && cnt_ff == CNT_BITS'(1)) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
         cnt_ff <= CNT_BITS'(DIVIDEND_BITS);
      end else if (busy_ff) begin
         // dividend bits leave the top as quotient bits enter the bottom
         quo_ff <= {quo_ff[DIVIDEND_BITS-2:0], fits};
         rem_ff <= fits ? K_BITS'(trial - {1'b0, den_ff}) : K_BITS'(trial);
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/gges_pickmul.sv =====
// bit-serial floor(u * k / 2^32), one bit of u per cycle
module gges_pickmul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [gges_pkg::U_BITS-1:0]  u_value,
   input  logic [gges_pkg::K_BITS-1:0]  k_value,
   output logic                         done,
   output logic [gges_pkg::K_BITS-1:0]  pick
);
   import gges_pkg::*;

   localparam int CNT_BITS = $clog2(U_BITS + 1);

   logic [U_BITS-1:0]   u_ff;
   logic [K_BITS-1:0]   k_ff;
   logic [K_BITS-1:0]   acc_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                busy_ff;
   logic                done_ff;

   logic [K_BITS:0] sum;

   assign sum = {1'b0, acc_ff} + (u_ff[0] ? {1'b0, k_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && cnt_ff == CNT_BITS'(1)) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         u_ff <= u_value;
         k_ff <= k_value;
         acc_ff <= '0;
         cnt_ff <= CNT_BITS'(U_BITS);
      end else if (busy_ff) begin
         // halving each step keeps the floor exact and the accumulator below k
         acc_ff <= sum[K_BITS:1];
         u_ff <= u_ff >> 1;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done = done_ff;
   assign pick = acc_ff;

endmodule

// ===== rtl/core/gillespie_gene_expression_step_core.sv =====
// top level of the gillespie direct-method step core
// One request word runs one stochastic step of the mRNA/protein model and gives one
// response word with the new time, both counts, the reaction taken and the horizon flag.
// The propensities are formed on one shared 32x16 multiplier. Meanwhile the log of
// u_time is found by a bit-serial normalise (started at acceptance and overlapped) plus
// the index, read-low, read-high, multiply and subtract states of lookup and
// interpolation. The waiting time then comes from a restoring divider on the 54-bit
// dividend while the reaction pick runs bit-serially beside it. The update and emit
// states then update state and load the response register. With zero total propensity
// the divider and pick are skipped. A new request is taken the cycle after the previous
// response is loaded, even if it has not yet been collected. A response that the sink
// holds back keeps the following step waiting in its final state.
module gillespie_gene_expression_step_core (
   input  logic                                 clock,
   input  logic                                 reset,
   gges_req_if.sink                             req_chan,
   gges_rsp_if.source                           rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [gges_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gges_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);
   import gges_pkg::*;

   ctl_state_type state_ff, state_in;

   logic [RATE_BITS-1:0]  mrna_birth_ff;
   logic [RATE_BITS-1:0]  mrna_decay_ff;
   logic [RATE_BITS-1:0]  prot_birth_ff;
   logic [RATE_BITS-1:0]  prot_decay_ff;
   logic [TIME_BITS-1:0]  horizon_ff;

   logic [TIME_BITS-1:0]  time_ff;
   logic [COUNT_BITS-1:0] mrna_ff;
   logic [COUNT_BITS-1:0] prot_ff;
   logic [U_BITS-1:0]     upick_ff;
   logic [1:0]            cnt_ff;
   logic [PROP_BITS-1:0]  prod_ff;
   logic [K_BITS-1:0]     cum1_ff;
   logic [K_BITS-1:0]     cum2_ff;
   logic [K_BITS-1:0]     k_ff;
   reaction_type          reaction_ff;

   logic                      rsp_valid_ff;
   logic [TIME_BITS-1:0]      o_time_ff;
   logic [COUNT_BITS-1:0]     o_mrna_ff;
   logic [COUNT_BITS-1:0]     o_prot_ff;
   logic [REACTION_BITS-1:0]  o_reaction_ff;
   logic                      o_horizon_ff;

   logic                     accept;
   logic                     units_start;
   logic                     emit;
   logic [U_BITS-1:0]        u_time_fixed;
   logic                     nl_valid;
   logic [NL_BITS-1:0]       nl_value;
   logic                     div_done;
   logic [DIVIDEND_BITS-1:0] dt;
   logic                     mul_done;
   logic [K_BITS-1:0]        pick;
   logic [RATE_BITS-1:0]     prop_rate;
   logic [COUNT_BITS-1:0]    prop_count;
   logic [DIVIDEND_BITS:0]   time_sum;
   logic [TIME_BITS-1:0]     time_next;
   reaction_type             pick_reaction;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign u_time_fixed = (req_chan.u_time == '0) ? U_BITS'(1) : req_chan.u_time;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mrna_birth_ff <= 32'd42949673;
         mrna_decay_ff <= 32'd24808701;
         prot_birth_ff <= 32'd496174020;
         prot_decay_ff <= 32'd826957;
         horizon_ff <= 48'd2359296000;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MRNA_BIRTH:    mrna_birth_ff <= csr_wr_data[RATE_BITS-1:0];
            CSR_MRNA_DECAY:    mrna_decay_ff <= csr_wr_data[RATE_BITS-1:0];
            CSR_PROTEIN_BIRTH: prot_birth_ff <= csr_wr_data[RATE_BITS-1:0];
            CSR_PROTEIN_DECAY: prot_decay_ff <= csr_wr_data[RATE_BITS-1:0];
            CSR_HORIZON:       horizon_ff <= csr_wr_data[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   gges_neglog u_neglog (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .u_value  (u_time_fixed),
      .nl_valid (nl_valid),
      .nl_value (nl_value)
   );

   gges_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (units_start),
      .dividend ({nl_value, {TIME_FRAC_BITS{1'b0}}}),
      .divisor  (k_ff),
      .done     (div_done),
      .quotient (dt)
   );

   gges_pickmul u_pickmul (
      .clock   (clock),
      .reset   (reset),
      .start   (units_start),
      .u_value (upick_ff),
      .k_value (k_ff),
      .done    (mul_done),
      .pick    (pick)
   );

   assign prop_rate = (cnt_ff == 2'd0) ? mrna_decay_ff :
                      (cnt_ff == 2'd1) ? prot_birth_ff : prot_decay_ff;
   assign prop_count = (cnt_ff == 2'd2) ? prot_ff : mrna_ff;

   assign time_sum = {{(DIVIDEND_BITS + 1 - TIME_BITS){1'b0}}, time_ff}
                     + {1'b0, dt};
   assign time_next = (|time_sum[DIVIDEND_BITS:TIME_BITS]) ? TIME_MAX
                      : time_sum[TIME_BITS-1:0];

   always_comb begin
      priority if (pick < K_BITS'(mrna_birth_ff)) begin
         pick_reaction = RX_MRNA_BIRTH;
      end else if (pick < cum1_ff) begin
         pick_reaction = RX_MRNA_DECAY;
      end else if (pick < cum2_ff) begin
         pick_reaction = RX_PROTEIN_BIRTH;
      end else begin
         pick_reaction = RX_PROTEIN_DECAY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         time_ff <= '0;
         mrna_ff <= '0;
         prot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && req_chan.restart) begin
            time_ff <= '0;
            mrna_ff <= '0;
            prot_ff <= '0;
         end else if (state_ff == S_UPD && k_ff != '0) begin
            time_ff <= time_next;
            unique case (pick_reaction)
               RX_MRNA_BIRTH:    if (mrna_ff != COUNT_MAX) mrna_ff <= mrna_ff + 1'b1;
               RX_MRNA_DECAY:    if (mrna_ff != '0) mrna_ff <= mrna_ff - 1'b1;
               RX_PROTEIN_BIRTH: if (prot_ff != COUNT_MAX) prot_ff <= prot_ff + 1'b1;
               RX_PROTEIN_DECAY: if (prot_ff != '0) prot_ff <= prot_ff - 1'b1;
               default: ;
            endcase
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         upick_ff <= req_chan.u_pick;
         cnt_ff <= 2'd0;
      end
      if (state_ff == S_PROP) begin
         cnt_ff <= cnt_ff + 1'b1;
         prod_ff <= prop_rate * prop_count;
         unique case (cnt_ff)
            2'd0: ;
            2'd1: cum1_ff <= K_BITS'(mrna_birth_ff) + K_BITS'(prod_ff);
            2'd2: cum2_ff <= cum1_ff + K_BITS'(prod_ff);
            2'd3: k_ff <= cum2_ff + K_BITS'(prod_ff);
            default: ;
         endcase
      end
      if (state_ff == S_UPD) begin
         reaction_ff <= (k_ff == '0) ? RX_NONE : pick_reaction;
      end
      if (emit) begin
         o_time_ff <= time_ff;
         o_mrna_ff <= mrna_ff;
         o_prot_ff <= prot_ff;
         o_reaction_ff <= reaction_ff;
         o_horizon_ff <= (time_ff >= horizon_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      units_start = 1'b0;
      emit = 1'b0;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_PROP;
         S_PROP: if (cnt_ff == 2'd3) state_in = S_LOG;
         S_LOG: begin
            if (k_ff == '0) begin
               state_in = S_UPD;
            end else if (nl_valid) begin
               units_start = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: if (div_done && mul_done) state_in = S_UPD;
         S_UPD: state_in = S_EMIT;
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.elapsed_time = o_time_ff;
   assign rsp_chan.mrna_out = o_mrna_ff;
   assign rsp_chan.protein_out = o_prot_ff;
   assign rsp_chan.reaction = o_reaction_ff;
   assign rsp_chan.horizon_reached = o_horizon_ff;

   // a fresh response only ever comes out of the emit state
   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("response raised outside emit");

   // a step with no propensity leaves time alone
   a_zero_k_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD && k_ff == '0) |=> $stable(time_ff) && $stable(mrna_ff))
      else $error("state moved on a zero-propensity step");

   // the divider is only ever fed a finished log value
   a_div_log: assert property (@(posedge clock) disable iff (reset)
      units_start |-> nl_valid && k_ff != '0)
      else $error("divider started without log value");

endmodule

// ===== tb/sv/tb_gillespie_gene_expression_step_core.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the gillespie step core with its own step predictor
module tb_gillespie_gene_expression_step_core;
   import gges_pkg::*;

   typedef struct {
      logic [U_BITS-1:0] u_time;
      logic [U_BITS-1:0] u_pick;
      logic              restart;
   } step_word_type;

   typedef struct {
      logic [TIME_BITS-1:0]  elapsed_time;
      logic [COUNT_BITS-1:0] mrna_out;
      logic [COUNT_BITS-1:0] protein_out;
      reaction_type          reaction;
      logic                  horizon_reached;
   } step_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data = '0;

   gges_req_if req_if ();
   gges_rsp_if rsp_if ();

   gillespie_gene_expression_step_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // predictor state and register copies
   logic [63:0] ln_lut [0:LOG_TABLE_DEPTH];
   logic [63:0] birth_m, decay_m, birth_p, decay_p, horizon;
   logic [63:0] now_t, n_mrna, n_prot;

   step_word_type   pending_words [$];
   step_result_type expected_results [$];
   int  mismatches = 0;
   bit  steady = 0;
   int  send_gap = 0;
   int  stall_gap = 0;

   function automatic void fill_ln_lut();
      logic [63:0] z, z2, term, acc;
      for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
         z = (64'(i) << 32) / 64'(2 * LOG_TABLE_DEPTH + i);
         z2 = (z * z) >> 32;
         term = z;
         acc = 0;
         for (int n = 0; n < 32 && term != 0; n++) begin
            acc += term / 64'(2 * n + 1);
            term = (term * z2) >> 32;
         end
         ln_lut[i] = acc << 1;
      end
   endfunction

   function automatic logic [63:0] minus_ln(logic [31:0] u_in);
      logic [63:0] u, frac, pos, j, w, lo, hi, lnm, whole;
      int e;
      u = (u_in == 0) ? 64'd1 : 64'(u_in);
      e = 31;
      while (e > 0 && u[e] == 1'b0) e--;
      frac = (u << (32 - e)) & 64'hFFFF_FFFF;
      pos = frac * LOG_TABLE_DEPTH;
      j = pos >> 32;
      w = pos & 64'hFFFF_FFFF;
      if (j >= LOG_TABLE_DEPTH) begin
         j = LOG_TABLE_DEPTH - 1;
         w = 64'hFFFF_FFFF;
      end
      lo = ln_lut[j];
      hi = ln_lut[j + 1];
      lnm = lo + ((hi >= lo) ? (((hi - lo) * w) >> 32) : 64'd0);
      whole = 64'(32 - e) * 64'(LN2_Q32);
      return (whole > lnm) ? whole - lnm : 64'd0;
   endfunction

   function automatic step_result_type next_step(step_word_type wd);
      step_result_type r;
      logic [63:0] a0, a1, a2, a3, k, dt, pick, u;
      reaction_type rx;
      rx = RX_NONE;
      if (wd.restart) begin
         now_t = 0;
         n_mrna = 0;
         n_prot = 0;
      end
      a0 = birth_m;
      a1 = decay_m * n_mrna;
      a2 = birth_p * n_mrna;
      a3 = decay_p * n_prot;
      k = a0 + a1 + a2 + a3;
      if (k != 0) begin
         dt = (minus_ln(wd.u_time) << TIME_FRAC_BITS) / k;
         u = 64'(wd.u_pick);
         pick = u * (k >> 32) + ((u * (k & 64'hFFFF_FFFF)) >> 32);
         now_t = (dt >= 64'(TIME_MAX) - now_t) ? 64'(TIME_MAX) : now_t + dt;
         if (pick < a0) begin
            rx = RX_MRNA_BIRTH;
            if (n_mrna < 64'(COUNT_MAX)) n_mrna++;
         end else if (pick < a0 + a1) begin
            rx = RX_MRNA_DECAY;
            if (n_mrna > 0) n_mrna--;
         end else if (pick < a0 + a1 + a2) begin
            rx = RX_PROTEIN_BIRTH;
            if (n_prot < 64'(COUNT_MAX)) n_prot++;
         end else begin
            rx = RX_PROTEIN_DECAY;
            if (n_prot > 0) n_prot--;
         end
      end
      r.elapsed_time = now_t[TIME_BITS-1:0];
      r.mrna_out = n_mrna[COUNT_BITS-1:0];
      r.protein_out = n_prot[COUNT_BITS-1:0];
      r.reaction = rx;
      r.horizon_reached = (now_t >= horizon);
      return r;
   endfunction

   // mostly short gaps, a few long ones, none during steady phases
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // request driver
   always @(posedge clock) begin
      step_word_type wd;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            wd.u_time = req_if.u_time;
            wd.u_pick = req_if.u_pick;
            wd.restart = req_if.restart;
            expected_results.push_back(next_step(wd));
            send_gap = draw_gap();
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               wd = pending_words.pop_front();
               req_if.u_time <= wd.u_time;
               req_if.u_pick <= wd.u_pick;
               req_if.restart <= wd.restart;
               req_if.valid <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      step_result_type e;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response word at %0t", $realtime);
            end else begin
               e = expected_results.pop_front();
               if (rsp_if.elapsed_time !== e.elapsed_time
                   || rsp_if.mrna_out !== e.mrna_out
                   || rsp_if.protein_out !== e.protein_out
                   || rsp_if.reaction !== e.reaction
                   || rsp_if.horizon_reached !== e.horizon_reached) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: exp t=%0d m=%0d p=%0d rx=%0d hz=%0b",
                        e.elapsed_time, e.mrna_out, e.protein_out, e.reaction,
                        e.horizon_reached);
                     $display("          got t=%0d m=%0d p=%0d rx=%0d hz=%0b",
                        rsp_if.elapsed_time, rsp_if.mrna_out, rsp_if.protein_out,
                        rsp_if.reaction, rsp_if.horizon_reached);
                  end
               end
            end
            stall_gap = draw_gap();
         end
         if (stall_gap > 0) begin
            stall_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   function automatic void queue_word(logic [31:0] ut, logic [31:0] up, logic rs);
      step_word_type wd;
      wd.u_time = ut;
      wd.u_pick = up;
      wd.restart = rs;
      pending_words.push_back(wd);
   endfunction

   function automatic void queue_random(int n);
      for (int i = 0; i < n; i++)
         queue_word($urandom, $urandom, $urandom_range(0, 99) < 4);
   endfunction

   task automatic wait_idle();
      while (pending_words.size() != 0 || expected_results.size() != 0 || req_if.valid)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   // writes all five registers back to back; an unknown index goes last
   task automatic load_regs(logic [31:0] bm, logic [31:0] dm, logic [31:0] bp,
                            logic [31:0] dp, logic [47:0] hz);
      logic [47:0] vals [5];
      vals = '{48'(bm), 48'(dm), 48'(bp), 48'(dp), hz};
      for (int i = 0; i < 5; i++) begin
         @(posedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= CSR_INDEX_BITS'(i);
         csr_wr_data <= vals[i];
      end
      @(posedge clock);
      csr_index <= 3'd7;
      csr_wr_data <= {16'($urandom), $urandom};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      birth_m = 64'(bm);
      decay_m = 64'(dm);
      birth_p = 64'(bp);
      decay_p = 64'(dp);
      horizon = 64'(hz);
   endtask

   function automatic logic [31:0] draw_rate();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(1, 1000);
         2: return $urandom >> $urandom_range(0, 31);
         default: return 32'(64'($urandom_range(1, 1000)) * 4294967);
      endcase
   endfunction

   initial begin
      fill_ln_lut();
      birth_m = 42949673;
      decay_m = 24808701;
      birth_p = 496174020;
      decay_p = 826957;
      horizon = 48'd2359296000;
      now_t = 0;
      n_mrna = 0;
      n_prot = 0;
      req_if.valid = 1'b0;
      req_if.u_time = '0;
      req_if.u_pick = '0;
      req_if.restart = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // defaults: extremes of the random words, zero u_time, restart
      queue_word(32'd0, 32'd0, 1'b1);
      queue_word(32'd1, 32'hFFFF_FFFF, 1'b0);
      queue_word(32'hFFFF_FFFF, 32'd0, 1'b0);
      queue_word(32'h8000_0000, 32'h8000_0000, 1'b0);
      queue_word(32'h0000_0002, 32'hFFFF_FFFF, 1'b0);
      queue_word(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
      queue_word(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
      queue_word(32'd0, 32'hFFFF_FFFF, 1'b0);
      wait_idle();

      // zero total propensity gives no reaction
      load_regs(32'd0, 32'd5, 32'd5, 32'd5, 48'd0);
      queue_word(32'h1234_5678, 32'd0, 1'b1);
      queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      wait_idle();

      // tiny rates: huge waiting times, time saturates
      load_regs(32'd1, 32'd1, 32'd1, 32'd1, TIME_MAX);
      queue_word(32'd1, 32'd0, 1'b1);
      for (int i = 0; i < 5; i++) queue_word(32'd1, $urandom, 1'b0);
      wait_idle();

      // largest rates: every reaction type reachable
      load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd1);
      queue_word(32'h0000_0003, 32'h0000_0001, 1'b1);
      for (int i = 0; i < 6; i++) queue_word($urandom, $urandom, 1'b0);
      wait_idle();

      for (int ph = 0; ph < 6; ph++) begin
         steady = (ph == 2);
         load_regs(draw_rate(), draw_rate(), draw_rate(), draw_rate(),
                   (ph == 3) ? TIME_MAX : {16'($urandom_range(0, 65535)), $urandom});
         queue_word($urandom, $urandom, 1'b1);
         queue_random(175);
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

endmodule
